// ----- rtl/htwd_pkg.sv -----
// Shared types and constants for the Huffman tree walk decoder.
package htwd_pkg;

    // Storage sizes of the child table and the stream word.
    localparam int TABLE_ENTRIES = 512;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
    localparam int WORD_BITS     = 32;
    localparam int PAYLOAD_W     = 32;
    localparam int WALK_BITS     = (WORD_BITS < PAYLOAD_W) ? WORD_BITS : PAYLOAD_W;
    localparam int BIT_IDX_W     = $clog2(WALK_BITS);

    // Field widths.
    localparam int NODE_W   = 9;
    localparam int LEN_W    = 24;
    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 2;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Input item operations.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_WORD  = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_LENGTH = 2'd0,
        CFG_ROOT_NODE    = 2'd1
    } cfg_idx_t;

    // One classified command for the back end.
    typedef struct packed {
        op_t                   op;
        logic [NODE_W-1:0]     index;
        logic [PAYLOAD_W-1:0]  payload;
    } cmd_t;

    // Configuration values seen by the back end.
    typedef struct packed {
        logic [LEN_W-1:0]  block_length;
        logic [NODE_W-1:0] root_node;
    } cfg_t;

endpackage

// ----- rtl/htwd_front.sv -----
// Front end: configuration registers and input item classification.
module htwd_front
    import htwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OPCODE_W-1:0]   s_opcode,
    input  logic [NODE_W-1:0]     s_table_index,
    input  logic [PAYLOAD_W-1:0]  s_payload,
    output logic                  push_valid,
    input  logic                  push_ready,
    output cmd_t                  push_cmd,
    output cfg_t                  cfg
);

    logic [LEN_W-1:0]  block_length_reg;
    logic [NODE_W-1:0] root_node_reg;
    logic              known_op;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_length_reg <= '0;
            root_node_reg    <= NODE_W'(256);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BLOCK_LENGTH: block_length_reg <= cfg_data[LEN_W-1:0];
                CFG_ROOT_NODE:    root_node_reg    <= cfg_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.block_length = block_length_reg;
    assign cfg.root_node    = root_node_reg;

    // Unknown opcodes are consumed here and never reach the queue.
    always_comb begin
        unique case (s_opcode)
            OP_LOAD, OP_START, OP_WORD: known_op = 1'b1;
            default:                    known_op = 1'b0;
        endcase
    end

    assign s_ready          = push_ready;
    assign push_valid       = s_valid && known_op;
    assign push_cmd.op      = op_t'(s_opcode);
    assign push_cmd.index   = s_table_index;
    assign push_cmd.payload = s_payload;

endmodule

// ----- rtl/htwd_cmd_fifo.sv -----
// Short command queue between the front end and the tree walker.
module htwd_cmd_fifo
    import htwd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_wr;
    logic                do_rd;

    assign wr_ready = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/htwd_back.sv -----
// Back end: child table memory, bitwise tree walk and result output.
module htwd_back
    import htwd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_t               cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BYTE_W-1:0]  m_out_byte,
    output logic               m_last_of_word,
    output logic               m_block_done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    state_t                state_reg, state_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [LEN_W-1:0]      bytes_left_reg, bytes_left_next;
    logic [PAYLOAD_W-1:0]  word_reg, word_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic [BYTE_W-1:0]     hold_byte_reg, hold_byte_next;
    logic                  hold_done_reg, hold_done_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    logic [NODE_W-1:0]     child_mem [TABLE_ENTRIES];
    logic [NODE_W-1:0]     rd_data_reg;
    logic [TBL_AW-1:0]     rd_addr;
    logic                  mem_we;

    logic [NODE_W-1:0]     root_val;
    logic                  is_leaf;
    logic                  slot_free;
    logic                  walk_stall;
    logic                  last_bit;
    logic                  last_byte;

    assign root_val   = {1'b1, cfg.root_node[NODE_W-2:0]};
    assign is_leaf    = !rd_data_reg[NODE_W-1];
    assign slot_free  = !out_valid_reg || m_ready;
    assign walk_stall = is_leaf && hold_valid_reg && !slot_free;
    assign last_bit   = bit_idx_reg == BIT_IDX_W'(WALK_BITS - 1);
    assign last_byte  = bytes_left_reg == LEN_W'(1);
    assign cmd_ready  = state_reg == ST_IDLE;

    // Next state of the walker. A decoded byte waits in the hold stage until
    // either another byte or the end of the word tells whether it is the last.
    always_comb begin
        state_next      = state_reg;
        node_next       = node_reg;
        bytes_left_next = bytes_left_reg;
        word_next       = word_reg;
        bit_idx_next    = bit_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_done_next  = hold_done_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        mem_we          = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    unique case (cmd.op)
                        OP_LOAD: begin
                            mem_we = 1'b1;
                        end
                        OP_START: begin
                            bytes_left_next = cfg.block_length;
                            node_next       = root_val;
                        end
                        OP_WORD: begin
                            if (bytes_left_reg != '0) begin
                                word_next    = cmd.payload;
                                bit_idx_next = '0;
                                state_next   = ST_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (!walk_stall) begin
                    bit_idx_next = bit_idx_reg + 1'b1;
                    if (is_leaf) begin
                        if (hold_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_byte_next  = hold_byte_reg;
                            out_last_next  = 1'b0;
                            out_done_next  = hold_done_reg;
                        end
                        hold_valid_next = 1'b1;
                        hold_byte_next  = rd_data_reg[BYTE_W-1:0];
                        hold_done_next  = last_byte;
                        bytes_left_next = bytes_left_reg - 1'b1;
                        node_next       = root_val;
                    end else begin
                        node_next = rd_data_reg;
                    end
                    if ((is_leaf && last_byte) || last_bit) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!hold_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = hold_byte_reg;
                    out_last_next   = 1'b1;
                    out_done_next   = hold_done_reg;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: ;
        endcase
    end

    // The read always follows the next node and bit, so the registered read
    // data matches the current node and bit.
    assign rd_addr = {node_next[BYTE_W-1:0], word_next[bit_idx_next]};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            child_mem[cmd.index] <= cmd.payload[NODE_W-1:0];
        end
        rd_data_reg <= child_mem[rd_addr];
    end

    // Control state and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_reg       <= NODE_W'(256);
            bytes_left_reg <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            node_reg       <= node_next;
            bytes_left_reg <= bytes_left_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        word_reg      <= word_next;
        bit_idx_reg   <= bit_idx_next;
        hold_byte_reg <= hold_byte_next;
        hold_done_reg <= hold_done_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_last_of_word = out_last_reg;
    assign m_block_done   = out_done_reg;

`ifndef SYNTHESIS
    // A held byte is always flushed before the walker goes idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !hold_valid_reg)
        else $error("held byte left behind in idle");

    // The byte that completes a block also closes its word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("block end without end of word");

    // The walk only runs while bytes remain in the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> bytes_left_reg != '0)
        else $error("walking with no bytes left");

    // A stalled walk keeps its position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK && walk_stall |=> $stable(bit_idx_reg) && $stable(node_reg))
        else $error("walk moved while stalled");
`endif

endmodule

// ----- rtl/huffman_tree_walk_decoder_top.sv -----
// Top level of the Huffman tree walk decoder.
//
// Items arrive on the s_ channel: opcode 0 writes one child table entry, opcode 1 starts a
// block of block_length bytes at root_node, opcode 2 supplies a 32-bit stream word that is
// decoded least significant bit first, opcode 3 is discarded. Each stream word produces up to
// 32 bytes on the m_ channel; the last byte of a word carries last_of_word and the byte that
// finishes the block carries block_done. The walker handles one command at a time: it applies
// a table write or start straight from the idle state, and it takes a stream word from the
// queue, walks it bit by bit until the word or the block ends, and then closes the word. Each
// tree step waits for the registered read of the previous step, since its address comes from
// that read data in the child table memory. When a decoded byte finds both the hold stage and
// the result register full, the walk waits, and the close of a word waits, until the result
// side takes a transfer. A two-entry command queue lets items be accepted while a word is
// being walked. Reading a table entry that was never written gives an undefined byte.
module huffman_tree_walk_decoder_top
    import htwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OPCODE_W-1:0]   s_opcode,
    input  logic [NODE_W-1:0]     s_table_index,
    input  logic [PAYLOAD_W-1:0]  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_out_byte,
    output logic                  m_last_of_word,
    output logic                  m_block_done
);

    cfg_t cfg;
    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;

    // Configuration and classification of incoming transfers.
    htwd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_table_index (s_table_index),
        .s_payload     (s_payload),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd),
        .cfg           (cfg)
    );

    // Command queue.
    htwd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_cmd   (push_cmd),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_cmd   (pop_cmd)
    );

    // Table memory and tree walker.
    htwd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd_valid      (pop_valid),
        .cmd_ready      (pop_ready),
        .cmd            (pop_cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_word (m_last_of_word),
        .m_block_done   (m_block_done)
    );

endmodule

// ----- tb/sv/htwd_byte_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Huffman tree walk decoder: predicts the decoded bytes and compares them.
module htwd_byte_checker
    import htwd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [OPCODE_W-1:0]   s_opcode,
    input  logic [NODE_W-1:0]     s_table_index,
    input  logic [PAYLOAD_W-1:0]  s_payload,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [BYTE_W-1:0]     m_out_byte,
    input  logic                  m_last_of_word,
    input  logic                  m_block_done,
    output int                    mismatches,
    output int                    bytes_outstanding
);

    // One byte that the decoder is expected to emit.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_word;
        logic              block_done;
    } decoded_byte_t;

    // Shadow copy of the decoder state and its registers.
    logic [NODE_W-1:0] child_slots [TABLE_ENTRIES];
    logic [NODE_W-1:0] walk_node;
    logic [LEN_W-1:0]  bytes_left;
    cfg_t              regs;
    decoded_byte_t     byte_q [$];
    int                fail_count = 0;

    // Walk one stream word, least significant bit first, and queue every byte it decodes.
    task automatic walk_word(input logic [PAYLOAD_W-1:0] word);
        logic [NODE_W-1:0] entry;
        decoded_byte_t     res;
        bit                emitted;
        emitted = 1'b0;
        for (int i = 0; i < WALK_BITS && bytes_left != 0; i++) begin
            entry = child_slots[{walk_node[7:0], word[i]}];
            if (!entry[NODE_W-1]) begin
                // A leaf: emit its byte and go back to the root.
                bytes_left       = bytes_left - 1'b1;
                res.out_byte     = entry[BYTE_W-1:0];
                res.last_of_word = 1'b0;
                res.block_done   = (bytes_left == 0);
                byte_q.push_back(res);
                emitted          = 1'b1;
                walk_node        = regs.root_node | 9'h100;
            end else begin
                walk_node = entry;
            end
        end
        // The last byte of the word carries the end-of-word flag.
        if (emitted) begin
            res              = byte_q.pop_back();
            res.last_of_word = 1'b1;
            byte_q.push_back(res);
        end
    endtask

    always @(posedge aclk) begin : monitor
        decoded_byte_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                child_slots[i] = '0;
            end
            walk_node         = 9'h100;
            bytes_left        = '0;
            regs.block_length = '0;
            regs.root_node    = 9'h100;
            byte_q.delete();
        end else begin
            // Result transfers belong to items accepted earlier, so they are checked first.
            if (m_valid && m_ready) begin
                if (byte_q.size() == 0) begin
                    $error("unexpected result: out_byte %02h last_of_word %0b block_done %0b",
                           m_out_byte, m_last_of_word, m_block_done);
                    fail_count++;
                end else begin
                    want = byte_q.pop_front();
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_out_byte);
                        fail_count++;
                    end
                    if (m_last_of_word !== want.last_of_word) begin
                        $error("last_of_word: expected %0b, got %0b",
                               want.last_of_word, m_last_of_word);
                        fail_count++;
                    end
                    if (m_block_done !== want.block_done) begin
                        $error("block_done: expected %0b, got %0b",
                               want.block_done, m_block_done);
                        fail_count++;
                    end
                end
            end

            // Register writes.
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BLOCK_LENGTH: regs.block_length = cfg_data[LEN_W-1:0];
                    CFG_ROOT_NODE:    regs.root_node    = cfg_data[NODE_W-1:0];
                    default: ;
                endcase
            end

            // Input item transfers.
            if (s_valid && s_ready) begin
                case (op_t'(s_opcode))
                    OP_LOAD:  child_slots[s_table_index] = s_payload[NODE_W-1:0];
                    OP_START: begin
                        bytes_left = regs.block_length;
                        walk_node  = regs.root_node | 9'h100;
                    end
                    OP_WORD:  if (bytes_left != 0) walk_word(s_payload);
                    default: ;
                endcase
            end
        end
        mismatches        <= fail_count;
        bytes_outstanding <= byte_q.size();
    end

endmodule

// ----- tb/sv/tb_huffman_tree_walk_decoder_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the Huffman tree walk decoder: stimulus, flow control and verdict.
module tb_huffman_tree_walk_decoder_top;
    import htwd_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 60;

    // Codes that the package leaves without a name.
    localparam logic [OPCODE_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } idle_mode_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [OPCODE_W-1:0]   s_opcode      = '0;
    logic [NODE_W-1:0]     s_table_index = '0;
    logic [PAYLOAD_W-1:0]  s_payload     = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [BYTE_W-1:0]     m_out_byte;
    logic                  m_last_of_word;
    logic                  m_block_done;

    int         mismatches;
    int         outstanding;
    int         items_sent   = 0;
    int         quiet_cycles = 0;
    int         hold_left    = 0;
    bit         hold_request = 1'b0;
    bit         hold_done    = 1'b0;
    idle_mode_t idle_mode    = PH_FREE;

    always #1 aclk = ~aclk;

    huffman_tree_walk_decoder_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_table_index  (s_table_index),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_word (m_last_of_word),
        .m_block_done   (m_block_done)
    );

    htwd_byte_checker i_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_table_index     (s_table_index),
        .s_payload         (s_payload),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_last_of_word    (m_last_of_word),
        .m_block_done      (m_block_done),
        .mismatches        (mismatches),
        .bytes_outstanding (outstanding)
    );

    // Result side: random stalls, plus one long hold-off that lets the decoder fill up.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else if (idle_mode == PH_RECV_STALL) begin
            m_ready <= ($urandom_range(99) >= 63);
        end else if (idle_mode == PH_BOTH) begin
            m_ready <= ($urandom_range(99) >= 15);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item and wait for its transfer; valid stays high unless a gap is taken.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [NODE_W-1:0] idx,
                             input logic [PAYLOAD_W-1:0] word);
        int gap_pct;
        gap_pct = (idle_mode == PH_BOTH) ? 15 : (idle_mode == PH_SEND_IDLE) ? 63 : 0;
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_table_index <= idx;
        s_payload     <= word;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic cfg_close();
        cfg_valid <= 1'b0;
    endtask

    // Stop offering items, wait for every expected byte, then let queued work run out.
    task automatic drain_decoder();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Load a random tree rooted at node 256 + root_lo. Children are written before any entry
    // points at them, so every node the walk can reach has both slots written.
    task automatic load_tree(input logic [7:0] root_lo, input int n_nodes);
        logic [NODE_W-1:0]    nodes [6];
        logic [NODE_W-1:0]    entry;
        logic [PAYLOAD_W-1:0] rnd;
        bit                   taken [256];
        int                   pick;
        nodes[0]       = {1'b1, root_lo};
        taken[root_lo] = 1'b1;
        for (int i = 1; i < n_nodes; i++) begin
            do pick = $urandom_range(255); while (taken[pick]);
            taken[pick] = 1'b1;
            nodes[i]    = {1'b1, pick[7:0]};
        end
        for (int i = n_nodes - 1; i >= 0; i--) begin
            for (int b = 0; b < 2; b++) begin
                if (i < n_nodes - 1 && $urandom_range(2) != 0) begin
                    entry = nodes[$urandom_range(n_nodes - 1, i + 1)];
                end else begin
                    entry = {1'b0, 8'($urandom)};
                end
                rnd = $urandom();
                send_item(OP_LOAD, {nodes[i][7:0], b[0]}, {rnd[31:9], entry});
            end
        end
    endtask

    // One block: new tree, registers, start, then stream words with some noise mixed in.
    task automatic run_episode();
        logic [7:0]           root_lo;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] rnd;
        int                   n_words;
        root_lo = 8'($urandom);
        load_tree(root_lo, $urandom_range(6, 1));
        drain_decoder();
        case ($urandom_range(9))
            0:       len = '0;
            1:       len = '1;
            2:       len = LEN_W'($urandom);
            default: len = LEN_W'($urandom_range(40, 1));
        endcase
        // Under pressure the block must yield enough bytes to back the decoder up.
        if (idle_mode == PH_PRESSURE && len < LEN_W'(3)) len = LEN_W'(40);
        rnd = $urandom();
        if ($urandom_range(3) != 0 || idle_mode == PH_PRESSURE) begin
            cfg_write(CFG_BLOCK_LENGTH, {rnd[31:24], len});
        end
        rnd = $urandom();
        cfg_write(CFG_ROOT_NODE, {rnd[31:8], root_lo});
        cfg_close();
        send_item(OP_START, NODE_W'($urandom), $urandom());
        if (idle_mode == PH_PRESSURE) hold_request <= 1'b1;
        n_words = $urandom_range(6, 1);
        for (int w = 0; w < n_words; w++) begin
            rnd = $urandom();
            case ($urandom_range(19))
                0: send_item(OP_UNUSED, NODE_W'($urandom), rnd);
                1: send_item(OP_START, NODE_W'($urandom), rnd);
                2: send_item(OP_LOAD, NODE_W'($urandom), {rnd[31:9], 1'b0, rnd[7:0]});
                3: send_item(OP_LOAD, NODE_W'($urandom), {rnd[31:9], 1'b1, root_lo});
                default: ;
            endcase
            send_item(OP_WORD, NODE_W'($urandom), $urandom());
        end
    endtask

    initial begin
        int phase_end;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Words and an unused opcode before any block is armed are ignored.
        send_item(OP_WORD, '1, '1);
        send_item(OP_UNUSED, '1, '1);
        // One-level tree at node 256, with junk above the entry bits.
        send_item(OP_LOAD, 9'd0, 32'hFFFF_FE00);
        send_item(OP_LOAD, 9'd1, 32'hFFFF_FEFF);
        // The reset length is zero, so the armed block emits nothing.
        send_item(OP_START, '1, '1);
        send_item(OP_WORD, '0, 32'h1234_5678);
        drain_decoder();

        // Longest block, plus a write to an index with no register behind it.
        cfg_write(CFG_BLOCK_LENGTH, 32'h00FF_FFFF);
        cfg_write(CFG_SPARE, '1);
        cfg_close();
        send_item(OP_START, '0, '0);
        send_item(OP_WORD, '0, 32'hAAAA_AAAA);
        send_item(OP_WORD, '1, 32'h0000_0000);
        send_item(OP_WORD, '0, 32'hFFFF_FFFF);
        drain_decoder();

        // One-byte block: the rest of the word and the next word are dropped.
        cfg_write(CFG_BLOCK_LENGTH, 32'hFF00_0001);
        cfg_close();
        send_item(OP_START, '0, '0);
        send_item(OP_WORD, '0, 32'h5555_5555);
        send_item(OP_WORD, '0, 32'h5555_5555);

        // Three-level tree at node 511, so symbols span word boundaries.
        send_item(OP_LOAD, 9'd288, 32'h0000_0001);
        send_item(OP_LOAD, 9'd289, 32'h0000_0002);
        send_item(OP_LOAD, 9'd88, 32'h0000_0190);
        send_item(OP_LOAD, 9'd89, 32'h0000_0080);
        send_item(OP_LOAD, 9'd510, 32'h0000_012C);
        send_item(OP_LOAD, 9'd511, 32'h0000_005A);
        drain_decoder();
        // Root written without bit 8, which the decoder forces on.
        cfg_write(CFG_BLOCK_LENGTH, 32'd40);
        cfg_write(CFG_ROOT_NODE, 32'h0000_00FF);
        cfg_close();
        send_item(OP_START, '0, '0);
        send_item(OP_WORD, '0, 32'h0000_0000);
        send_item(OP_WORD, '0, 32'hFFFF_FFFF);
        // Restart in the middle of a block.
        send_item(OP_START, '0, '0);
        send_item(OP_WORD, '0, $urandom());
        send_item(OP_WORD, '0, $urandom());
        drain_decoder();

        // Random blocks under each flow-control mode in turn.
        for (int m = PH_FREE; m <= PH_PRESSURE; m++) begin
            idle_mode <= idle_mode_t'(m);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_episode();
        end
        idle_mode <= PH_FREE;
        drain_decoder();

        if (mismatches == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/htwd_pkg.sv
rtl/htwd_front.sv
rtl/htwd_cmd_fifo.sv
rtl/htwd_back.sv
rtl/huffman_tree_walk_decoder_top.sv
tb/sv/htwd_byte_checker.sv
tb/sv/tb_huffman_tree_walk_decoder_top.sv
